FILE: design/ebb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the box blur.
`timescale 1ns / 1ps

package ebb_pkg;

  // Default sizing of the frame store and window
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;

  // Field widths
  localparam int COORD_W    = 8;
  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 3 * CHAN_W;
  localparam int DIM_W      = 9;
  localparam int RAD_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  // Wide enough to compare coordinates against any size limit
  localparam int EXT_W      = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;

  // Configuration reset values
  localparam logic [DIM_W-1:0] RST_IMG_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_IMG_HEIGHT = 9'd256;
  localparam logic [RAD_W-1:0] RST_RADIUS     = 4'd1;

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BLUR = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store;      // write the incoming pixel word into the frame store
    logic capture;    // latch the query coordinates
    logic setup;      // compute window bounds, clear the sums
    logic issue;      // read one window pixel and advance the scan
    logic div_start;  // launch the three dividers
    logic out_load;   // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic oob;        // query lies outside the image
    logic scan_last;  // scan points at the last window pixel
    logic div_busy;   // dividers still iterating
    logic out_free;   // result register can take a new word
  } ctrl_status_t;

endpackage

FILE: design/edge_clipped_box_blur.sv
// Top level of the edge-clipped box blur: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per item. A load
//   word (command_i = 0) writes red/green/blue into the frame store at
//   (col_i, row_i); it yields no result. A blur word (command_i = 1) scans
//   the in-bounds window around (col_i, row_i) and yields one result word on
//   the output channel (out_valid_o/out_ready_i). The channel sums are 18
//   bits wide for a maximum radius of 15. The scan reads one pixel per cycle
//   from the single read port of the frame store, then three restoring
//   dividers produce one quotient bit a cycle. A query outside the image
//   returns zeros with no scan or division. Only one blur is in flight. The
//   result sits in an output register: loads keep being accepted while it
//   waits; a finished blur waits for the register to drain if the receiver
//   stalls. Configuration writes (cfg_valid_i) are taken every cycle and
//   belong to idle periods. Reset clears control state and puts the
//   registers to 256x256, radius 1; the frame store is not cleared.

module edge_clipped_box_blur #(
  parameter int MAX_WIDTH  = ebb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ebb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = ebb_pkg::DEF_MAX_RADIUS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [ebb_pkg::COORD_W-1:0]    col_i,
  input  logic [ebb_pkg::COORD_W-1:0]    row_i,
  input  logic [ebb_pkg::CHAN_W-1:0]     red_in_i,
  input  logic [ebb_pkg::CHAN_W-1:0]     green_in_i,
  input  logic [ebb_pkg::CHAN_W-1:0]     blue_in_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ebb_pkg::COORD_W-1:0]    out_col_o,
  output logic [ebb_pkg::COORD_W-1:0]    out_row_o,
  output logic [ebb_pkg::CHAN_W-1:0]     red_out_o,
  output logic [ebb_pkg::CHAN_W-1:0]     green_out_o,
  output logic [ebb_pkg::CHAN_W-1:0]     blue_out_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ebb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ebb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ebb_pkg::ctrl_cmd_t    cmd;
  ebb_pkg::ctrl_status_t status;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequence each item: accept, set up window, scan, divide, hand off
  ebb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the frame store, sums, dividers and result register
  ebb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .col_i       (col_i),
    .row_i       (row_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

endmodule

FILE: design/ebb_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ebb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ebb_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ebb_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Shift one dividend bit into the partial remainder and try the subtract
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      step_d = STEP_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d  = {num_q[NUM_W-2:0], fits};
      step_d = step_q - 1'b1;
      busy_d = (step_q != STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;

endmodule

FILE: design/ebb_datapath.sv
// Datapath: config registers, frame store, window scan, sums, dividers, result register.
`timescale 1ns / 1ps

module ebb_datapath #(
  parameter int MAX_WIDTH  = ebb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ebb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = ebb_pkg::DEF_MAX_RADIUS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ebb_pkg::ctrl_cmd_t               cmd_i,
  output ebb_pkg::ctrl_status_t            status_o,
  input  logic [ebb_pkg::COORD_W-1:0]      col_i,
  input  logic [ebb_pkg::COORD_W-1:0]      row_i,
  input  logic [ebb_pkg::CHAN_W-1:0]       red_in_i,
  input  logic [ebb_pkg::CHAN_W-1:0]       green_in_i,
  input  logic [ebb_pkg::CHAN_W-1:0]       blue_in_i,
  input  logic                             cfg_valid_i,
  input  logic [ebb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ebb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ebb_pkg::COORD_W-1:0]      out_col_o,
  output logic [ebb_pkg::COORD_W-1:0]      out_row_o,
  output logic [ebb_pkg::CHAN_W-1:0]       red_out_o,
  output logic [ebb_pkg::CHAN_W-1:0]       green_out_o,
  output logic [ebb_pkg::CHAN_W-1:0]       blue_out_o
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = 1 << (CW + RW);
  localparam int AW    = CW + RW;
  localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W = CNT_W + ebb_pkg::CHAN_W;
  localparam int CMP_W = 7;

  localparam int XW = ebb_pkg::COORD_W;
  localparam int EW = ebb_pkg::EXT_W;
  localparam int DW = ebb_pkg::DIM_W;
  localparam int RDW = ebb_pkg::RAD_W;
  localparam int CH = ebb_pkg::CHAN_W;

  // Configuration registers
  logic [DW-1:0]  img_width_q, img_height_q;
  logic [RDW-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= ebb_pkg::RST_IMG_WIDTH;
      img_height_q <= ebb_pkg::RST_IMG_HEIGHT;
      radius_q     <= ebb_pkg::RST_RADIUS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ebb_pkg::CFG_IMG_WIDTH:  img_width_q  <= cfg_data_i;
        ebb_pkg::CFG_IMG_HEIGHT: img_height_q <= cfg_data_i;
        ebb_pkg::CFG_RADIUS:     radius_q     <= cfg_data_i[RDW-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping
  logic [EW-1:0]  w_ext, h_ext;
  logic [DW-1:0]  w_eff, h_eff;
  logic [RDW-1:0] r_eff;

  always_comb begin
    w_ext = (img_width_q == '0) ? EW'(1) :
            ({{(EW-DW){1'b0}}, img_width_q} > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) :
            {{(EW-DW){1'b0}}, img_width_q};
    h_ext = (img_height_q == '0) ? EW'(1) :
            ({{(EW-DW){1'b0}}, img_height_q} > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) :
            {{(EW-DW){1'b0}}, img_height_q};
    w_eff = w_ext[DW-1:0];
    h_eff = h_ext[DW-1:0];
    r_eff = ({{(CMP_W-RDW){1'b0}}, radius_q} > CMP_W'(MAX_RADIUS)) ?
            RDW'(MAX_RADIUS) : radius_q;
  end

  // Query coordinates and window bounds
  logic [XW-1:0] col_q, row_q;
  logic [XW-1:0] x_q, y_q, x0_q, x1_q, y1_q;
  logic          oob, oob_q;
  logic [XW-1:0] x0, y0, x1, y1;
  logic [DW-1:0] col_far, row_far;

  always_comb begin
    oob     = ({1'b0, col_q} >= w_eff) || ({1'b0, row_q} >= h_eff);
    col_far = {1'b0, col_q} + {{(DW-RDW){1'b0}}, r_eff};
    row_far = {1'b0, row_q} + {{(DW-RDW){1'b0}}, r_eff};
    x0 = (col_q > {{(XW-RDW){1'b0}}, r_eff}) ? col_q - {{(XW-RDW){1'b0}}, r_eff} : '0;
    y0 = (row_q > {{(XW-RDW){1'b0}}, r_eff}) ? row_q - {{(XW-RDW){1'b0}}, r_eff} : '0;
    x1 = (col_far >= w_eff) ? XW'(w_eff - 1'b1) : col_far[XW-1:0];
    y1 = (row_far >= h_eff) ? XW'(h_eff - 1'b1) : row_far[XW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (cmd_i.setup) begin
      oob_q <= oob;
      x0_q  <= x0;
      x1_q  <= x1;
      y1_q  <= y1;
      x_q   <= x0;
      y_q   <= y0;
    end else if (cmd_i.issue) begin
      // Raster order: wrap to the left edge at the end of each row
      if (x_q == x1_q) begin
        x_q <= x0_q;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

  // Frame store
  logic [EW-1:0]  wcol_ext, wrow_ext, rcol_ext, rrow_ext;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [ebb_pkg::PIXEL_W-1:0] rdata;

  always_comb begin
    wcol_ext = {{(EW-XW){1'b0}}, col_i};
    wrow_ext = {{(EW-XW){1'b0}}, row_i};
    rcol_ext = {{(EW-XW){1'b0}}, x_q};
    rrow_ext = {{(EW-XW){1'b0}}, y_q};
    we    = cmd_i.store && (wcol_ext < EW'(MAX_WIDTH)) && (wrow_ext < EW'(MAX_HEIGHT));
    waddr = {wrow_ext[RW-1:0], wcol_ext[CW-1:0]};
    raddr = {rrow_ext[RW-1:0], rcol_ext[CW-1:0]};
  end

  ebb_ram #(
    .WIDTH (ebb_pkg::PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Accumulate read data in the cycle after its address is issued
  logic             rd_pend_q;
  logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
      cnt_q   <= '0;
    end else if (rd_pend_q) begin
      sum_r_q <= sum_r_q + SUM_W'(rdata[3*CH-1:2*CH]);
      sum_g_q <= sum_g_q + SUM_W'(rdata[2*CH-1:CH]);
      sum_b_q <= sum_b_q + SUM_W'(rdata[CH-1:0]);
      cnt_q   <= cnt_q + 1'b1;
    end
  end

  // Three dividers, one per channel
  logic             busy_r, busy_g, busy_b;
  logic [SUM_W-1:0] quot_r, quot_g, quot_b;

  ebb_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (cmd_i.div_start),
    .num_i (sum_r_q), .den_i (cnt_q), .busy_o (busy_r), .quot_o (quot_r)
  );

  ebb_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (cmd_i.div_start),
    .num_i (sum_g_q), .den_i (cnt_q), .busy_o (busy_g), .quot_o (quot_g)
  );

  ebb_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (cmd_i.div_start),
    .num_i (sum_b_q), .den_i (cnt_q), .busy_o (busy_b), .quot_o (quot_b)
  );

  // Result register
  logic          out_valid_q;
  logic [XW-1:0] out_col_q, out_row_q;
  logic [CH-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_q <= col_q;
      out_row_q <= row_q;
      red_q     <= oob_q ? '0 : quot_r[CH-1:0];
      green_q   <= oob_q ? '0 : quot_g[CH-1:0];
      blue_q    <= oob_q ? '0 : quot_b[CH-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

  always_comb begin
    status_o.oob       = oob;
    status_o.scan_last = (x_q == x1_q) && (y_q == y1_q);
    status_o.div_busy  = busy_r || busy_g || busy_b;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

FILE: design/ebb_ctrl.sv
// Controller state machine sequencing load, scan, divide and result hand-off.
`timescale 1ns / 1ps

module ebb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  ebb_pkg::ctrl_status_t status_i,
  output ebb_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    SETUP,
    SCAN,
    DRAIN,
    DIV_START,
    DIV_WAIT,
    FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == ebb_pkg::CMD_BLUR) begin
            cmd_o.capture = 1'b1;
            state_d       = SETUP;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = status_i.oob ? FINISH : SCAN;
      end
      SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = DRAIN;
        end
      end
      DRAIN: begin
        // last read word lands in the sums here
        state_d = DIV_START;
      end
      DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = DIV_WAIT;
      end
      DIV_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = FINISH;
        end
      end
      FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
